// ===== sv/window_pose_averager_assert.svh =====
// ----------------------------------------------------------------------------
// window pose averager assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef WINDOW_POSE_AVERAGER_ASSERT_SVH
`define WINDOW_POSE_AVERAGER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define WPA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define WPA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wpa_pkg.sv =====
// ----------------------------------------------------------------------------
// wpa_pkg
// types and constants shared by the window pose averager modules
// ----------------------------------------------------------------------------
package wpa_pkg;

    localparam int MAX_WINDOW_DEF = 16;

    // packed measurement: pos_x, pos_y, pos_z, q_x, q_y, q_z, q_w from lsb
    localparam int ENTRY_W   = 160;
    localparam int RESULT_W  = 256;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 5'd10;
    localparam logic [CFG_W-1:0] MIN_MEAS_RST    = 5'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEAS    = 1'b1;

    // unit quaternion component in q2.14
    localparam logic [15:0] Q_ONE = 16'd16384;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } wpa_op_t;

    typedef struct packed {
        wpa_op_t              opcode;
        logic [ENTRY_W-1:0]   payload;
    } wpa_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] win_size;
        logic [CFG_W-1:0] min_meas;
    } wpa_cfg_t;

endpackage

// ===== sv/wpa_ram.sv =====
// ----------------------------------------------------------------------------
// wpa_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wpa_div.sv =====
// ----------------------------------------------------------------------------
// wpa_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wpa_div #(
    parameter int DIV_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] num,
    input  logic [DIV_W-1:0] den,
    output logic             done,
    output logic [DIV_W-1:0] quo
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rem_reg  <= '0;
                quo_reg  <= num;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (fits) begin
                    rem_reg <= DIV_W'(trial - {1'b0, den_reg});
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[DIV_W-1:0];
                    quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== sv/wpa_front.sv =====
// ----------------------------------------------------------------------------
// wpa_front
// input acceptance, configuration registers and a two-item queue
// ----------------------------------------------------------------------------
module wpa_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [wpa_pkg::ENTRY_W-1:0] s_tdata,
    input  logic [0:0]                  s_tuser,
    input  logic                        cfg_wr_en,
    input  logic [wpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wpa_pkg::CFG_W-1:0]   cfg_data,
    output wpa_pkg::wpa_cfg_t           cfg,
    output logic                        q_valid,
    output wpa_pkg::wpa_item_t          q_item,
    input  logic                        q_pop
);
    import wpa_pkg::*;

    wpa_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    wpa_cfg_t   cfg_reg;
    logic       push;
    logic       pop;

    assign s_tready = cnt_reg != 2'd2;
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg       <= 1'b0;
            rd_ptr_reg       <= 1'b0;
            cnt_reg          <= 2'd0;
            cfg_reg.win_size <= WINDOW_SIZE_RST;
            cfg_reg.min_meas <= MIN_MEAS_RST;
        end else begin
            if (push) begin
                slot_reg[wr_ptr_reg].opcode  <= wpa_op_t'(s_tuser[0]);
                slot_reg[wr_ptr_reg].payload <= s_tdata;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_WINDOW_SIZE: cfg_reg.win_size <= cfg_data;
                    CFG_MIN_MEAS:    cfg_reg.min_meas <= cfg_data;
                    default:         cfg_reg          <= cfg_reg;
                endcase
            end
        end
    end

    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = slot_reg[rd_ptr_reg];
    assign cfg     = cfg_reg;

endmodule

// ===== sv/wpa_back.sv =====
// ----------------------------------------------------------------------------
// wpa_back
// ring maintenance and the per-tick mean, quaternion and variance sequencer
// ----------------------------------------------------------------------------
module wpa_back #(
    parameter int MAX_WINDOW = wpa_pkg::MAX_WINDOW_DEF,
    parameter int AW         = $clog2(MAX_WINDOW),
    parameter int CW         = $clog2(MAX_WINDOW + 1),
    parameter int DIV_W      = 50 + CW
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  wpa_pkg::wpa_cfg_t            cfg,
    input  logic                         q_valid,
    input  wpa_pkg::wpa_item_t           q_item,
    output logic                         q_pop,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [wpa_pkg::ENTRY_W-1:0]  ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic [wpa_pkg::ENTRY_W-1:0]  ram_rdata,
    output logic                         div_start,
    output logic [DIV_W-1:0]             div_num,
    output logic [DIV_W-1:0]             div_den,
    input  logic                         div_done,
    input  logic [DIV_W-1:0]             div_quo,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [wpa_pkg::RESULT_W-1:0] m_tdata,
    output logic [0:0]                   m_tuser
);
    import wpa_pkg::*;

    localparam int PS_W  = 32 + CW;
    localparam int QS_W  = 16 + CW;
    localparam int SQ_W  = 2 * QS_W;
    localparam int ACC_W = 49 + CW;
    localparam int VS_W  = 65;
    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;
    localparam int SUM_W = CW + 1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_PDROP, ST_PWRITE, ST_SRD, ST_SACC, ST_MEAN_GO, ST_MEAN_WT,
        ST_QMUL, ST_QADD, ST_SQRT, ST_QUAT_GO, ST_QUAT_WT, ST_VRD, ST_VDIFF,
        ST_VMUL, ST_VADD, ST_VAR_GO, ST_VAR_WT, ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            oldest_reg;
    logic [CW-1:0]            idx_reg;
    logic [AW-1:0]            addr_reg;
    logic [1:0]               k_reg;
    logic [ENTRY_W-1:0]       item_reg;

    logic signed [PS_W-1:0]   psum_reg [3];
    logic signed [QS_W-1:0]   qsum_reg [4];
    logic signed [31:0]       mean_reg [3];
    logic [15:0]              quat_reg [4];
    logic                     qvalid_reg;
    logic [31:0]              var_reg  [3];
    logic [ACC_W-1:0]         acc_reg  [3];
    logic [2:0]               sat_reg;

    logic [SQ_W-1:0]          qprod_reg;
    logic [SQ_W-1:0]          ssq_reg;
    logic [SQ_W-1:0]          sq_x_reg;
    logic [SQ_W-1:0]          sq_r_reg;
    logic [SQ_W-1:0]          sq_bit_reg;

    logic [32:0]              absd_reg;
    logic [63:0]              vprod_reg;
    logic                     vbig_reg;

    logic                     m_tvalid_reg;
    logic [RESULT_W-1:0]      m_tdata_reg;
    logic                     m_tuser_reg;

    // ring index arithmetic
    logic [AW-1:0]            addr_inc;
    logic [CMP_W-1:0]         win_eff;
    logic [CMP_W-1:0]         count_ext;
    logic [SUM_W-1:0]         drop_sum;
    logic [SUM_W-1:0]         slot_sum;
    logic [AW-1:0]            slot;

    // per-entry field views
    logic signed [31:0]       rd_pos   [3];
    logic signed [15:0]       rd_q     [4];

    logic [QS_W-1:0]          qabs;
    logic [PS_W-1:0]          pabs;
    logic [SQ_W-1:0]          ssq_sum;
    logic [SQ_W:0]            sq_trial;
    logic signed [32:0]       diff;
    logic [VS_W-1:0]          vsum;
    logic [VS_W-1:0]          vlimit;
    logic [15:0]              qclamp;
    logic [31:0]              mq;
    logic                     last_entry;
    logic                     out_fire;

    assign addr_inc  = (addr_reg == AW'(MAX_WINDOW - 1)) ? '0 : addr_reg + 1'b1;
    assign count_ext = CMP_W'(count_reg);
    assign last_entry = idx_reg == count_reg - 1'b1;
    assign out_fire  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (cfg.win_size == '0) begin
            win_eff = CMP_W'(1);
        end else if (CMP_W'(cfg.win_size) > CMP_W'(MAX_WINDOW)) begin
            win_eff = CMP_W'(MAX_WINDOW);
        end else begin
            win_eff = CMP_W'(cfg.win_size);
        end
    end

    // oldest advanced past the dropped entries, and the free slot after the last
    assign drop_sum = SUM_W'(oldest_reg) + SUM_W'(count_ext - win_eff + 1'b1);
    assign slot_sum = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign slot     = (slot_sum >= SUM_W'(MAX_WINDOW)) ?
                      AW'(slot_sum - SUM_W'(MAX_WINDOW)) : AW'(slot_sum);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            rd_pos[i] = ram_rdata[32*i +: 32];
        end
        for (int i = 0; i < 4; i++) begin
            rd_q[i] = ram_rdata[96 + 16*i +: 16];
        end
    end

    assign qabs    = qsum_reg[k_reg][QS_W-1] ? QS_W'(-qsum_reg[k_reg]) : qsum_reg[k_reg];
    assign pabs    = psum_reg[k_reg][PS_W-1] ? PS_W'(-psum_reg[k_reg]) : psum_reg[k_reg];
    assign ssq_sum = ssq_reg + qprod_reg;
    assign sq_trial = {1'b0, sq_r_reg} + {1'b0, sq_bit_reg};
    assign diff    = {rd_pos[k_reg][31], rd_pos[k_reg]} -
                     {mean_reg[k_reg][31], mean_reg[k_reg]};
    assign vsum    = VS_W'(acc_reg[k_reg]) + VS_W'(vprod_reg);
    assign vlimit  = VS_W'(count_reg) << 48;
    assign qclamp  = (div_quo > DIV_W'(Q_ONE)) ? Q_ONE : div_quo[15:0];
    assign mq      = div_quo[31:0];

    // divider operands follow the phase of the sequencer
    always_comb begin
        div_start = 1'b0;
        div_num   = DIV_W'(pabs);
        div_den   = DIV_W'(count_reg);
        unique case (state_reg)
            ST_MEAN_GO: begin
                div_start = 1'b1;
            end
            ST_QUAT_GO, ST_QUAT_WT: begin
                div_start = state_reg == ST_QUAT_GO;
                div_num   = (DIV_W'(qabs) << 15) + DIV_W'(sq_r_reg);
                div_den   = DIV_W'(sq_r_reg) << 1;
            end
            ST_VAR_GO, ST_VAR_WT: begin
                div_start = (state_reg == ST_VAR_GO) && !sat_reg[k_reg];
                div_num   = DIV_W'(acc_reg[k_reg]);
                div_den   = DIV_W'(count_reg) << 16;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign ram_we    = state_reg == ST_PWRITE;
    assign ram_waddr = slot;
    assign ram_wdata = item_reg;
    assign ram_re    = (state_reg == ST_SRD) || (state_reg == ST_VRD);
    assign ram_raddr = addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            oldest_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            k_reg        <= '0;
        end else begin
            if (out_fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        item_reg <= q_item.payload;
                        if (q_item.opcode == OP_PUSH) begin
                            state_reg <= ST_PDROP;
                        end else if (count_reg == '0 ||
                                     count_ext < CMP_W'(cfg.min_meas)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            for (int i = 0; i < 3; i++) psum_reg[i] <= '0;
                            for (int i = 0; i < 4; i++) qsum_reg[i] <= '0;
                            idx_reg   <= '0;
                            addr_reg  <= oldest_reg;
                            state_reg <= ST_SRD;
                        end
                    end
                end
                ST_PDROP: begin
                    if (count_ext >= win_eff) begin
                        count_reg  <= CW'(win_eff - 1'b1);
                        oldest_reg <= (drop_sum >= SUM_W'(MAX_WINDOW)) ?
                                      AW'(drop_sum - SUM_W'(MAX_WINDOW)) : AW'(drop_sum);
                    end
                    state_reg <= ST_PWRITE;
                end
                ST_PWRITE: begin
                    count_reg <= count_reg + 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_SRD: begin
                    state_reg <= ST_SACC;
                end
                ST_SACC: begin
                    for (int i = 0; i < 3; i++) begin
                        psum_reg[i] <= psum_reg[i] + PS_W'(rd_pos[i]);
                    end
                    for (int i = 0; i < 4; i++) begin
                        qsum_reg[i] <= qsum_reg[i] + QS_W'(rd_q[i]);
                    end
                    if (last_entry) begin
                        k_reg     <= '0;
                        state_reg <= ST_MEAN_GO;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        addr_reg  <= addr_inc;
                        state_reg <= ST_SRD;
                    end
                end
                ST_MEAN_GO: begin
                    state_reg <= ST_MEAN_WT;
                end
                ST_MEAN_WT: begin
                    if (div_done) begin
                        mean_reg[k_reg] <= psum_reg[k_reg][PS_W-1] ? -mq : mq;
                        if (k_reg == 2'd2) begin
                            k_reg     <= '0;
                            ssq_reg   <= '0;
                            state_reg <= ST_QMUL;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_MEAN_GO;
                        end
                    end
                end
                ST_QMUL: begin
                    qprod_reg <= SQ_W'(qabs) * SQ_W'(qabs);
                    state_reg <= ST_QADD;
                end
                ST_QADD: begin
                    ssq_reg <= ssq_sum;
                    if (k_reg == 2'd3) begin
                        k_reg <= '0;
                        if (ssq_sum == '0) begin
                            for (int i = 0; i < 4; i++) quat_reg[i] <= '0;
                            qvalid_reg <= 1'b0;
                            idx_reg    <= '0;
                            addr_reg   <= oldest_reg;
                            sat_reg    <= '0;
                            for (int i = 0; i < 3; i++) acc_reg[i] <= '0;
                            state_reg  <= ST_VRD;
                        end else begin
                            sq_x_reg   <= ssq_sum;
                            sq_r_reg   <= '0;
                            sq_bit_reg <= SQ_W'(1) << (SQ_W - 2);
                            state_reg  <= ST_SQRT;
                        end
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_QMUL;
                    end
                end
                ST_SQRT: begin
                    // one result bit per step, starting from the top pair of radicand bits
                    if ({1'b0, sq_x_reg} >= sq_trial) begin
                        sq_x_reg <= SQ_W'({1'b0, sq_x_reg} - sq_trial);
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        k_reg     <= '0;
                        state_reg <= ST_QUAT_GO;
                    end
                end
                ST_QUAT_GO: begin
                    state_reg <= ST_QUAT_WT;
                end
                ST_QUAT_WT: begin
                    if (div_done) begin
                        quat_reg[k_reg] <= qsum_reg[k_reg][QS_W-1] ? -qclamp : qclamp;
                        if (k_reg == 2'd3) begin
                            qvalid_reg <= 1'b1;
                            k_reg      <= '0;
                            idx_reg    <= '0;
                            addr_reg   <= oldest_reg;
                            sat_reg    <= '0;
                            for (int i = 0; i < 3; i++) acc_reg[i] <= '0;
                            state_reg  <= ST_VRD;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_QUAT_GO;
                        end
                    end
                end
                ST_VRD: begin
                    k_reg     <= '0;
                    state_reg <= ST_VDIFF;
                end
                ST_VDIFF: begin
                    absd_reg  <= diff[32] ? 33'(-diff) : 33'(diff);
                    state_reg <= ST_VMUL;
                end
                ST_VMUL: begin
                    vprod_reg <= absd_reg[31:0] * absd_reg[31:0];
                    vbig_reg  <= absd_reg[32];
                    state_reg <= ST_VADD;
                end
                ST_VADD: begin
                    // accumulator stops and the axis is flagged saturated once it would reach the limit
                    if (!sat_reg[k_reg]) begin
                        if (vbig_reg || vsum >= vlimit) begin
                            sat_reg[k_reg] <= 1'b1;
                        end else begin
                            acc_reg[k_reg] <= ACC_W'(vsum);
                        end
                    end
                    if (k_reg == 2'd2) begin
                        k_reg <= '0;
                        if (last_entry) begin
                            state_reg <= ST_VAR_GO;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            addr_reg  <= addr_inc;
                            state_reg <= ST_VRD;
                        end
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_VDIFF;
                    end
                end
                ST_VAR_GO: begin
                    if (sat_reg[k_reg]) begin
                        var_reg[k_reg] <= '1;
                        if (k_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end else begin
                        state_reg <= ST_VAR_WT;
                    end
                end
                ST_VAR_WT: begin
                    if (div_done) begin
                        var_reg[k_reg] <= div_quo[31:0];
                        if (k_reg == 2'd2) begin
                            state_reg <= ST_OUT;
                        end else begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= ST_VAR_GO;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_fire) begin
                        m_tuser_reg  <= qvalid_reg;
                        m_tdata_reg  <= {var_reg[2], var_reg[1], var_reg[0],
                                         quat_reg[3], quat_reg[2], quat_reg[1], quat_reg[0],
                                         mean_reg[2], mean_reg[1], mean_reg[0]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== sv/window_pose_averager.sv =====
// ----------------------------------------------------------------------------
// window_pose_averager
// sliding-window mean, quaternion average and position variance of poses
// ----------------------------------------------------------------------------
// A push item stores one pose (q16.16 position, q2.14 quaternion) in a ring
// of up to MAX_WINDOW entries, dropping the oldest so that at most the
// window register's count remain; it gives no result. A tick item with at
// least the minimum-count register's number stored (and at least one)
// yields one result: truncated mean position, the summed quaternion scaled
// to unit length (quat_valid low and zeros when that sum is zero) and the
// saturated population variance per axis. A tick's run time is set by the
// single shared divider, which retires one quotient bit per cycle for up to
// ten divisions of DIV_W = 50 + clog2(MAX_WINDOW + 1) bits (quaternion ones
// skipped when the sum is zero, variance ones for saturated axes), by the
// SQ_W/2 = 16 + clog2(MAX_WINDOW + 1) square-root steps, and by the two
// walks over the ring through its one read port. A two-item queue behind
// the input and the output register let either side stall; the ring memory
// needs no clearing.
// ----------------------------------------------------------------------------
module window_pose_averager #(
    parameter int MAX_WINDOW = wpa_pkg::MAX_WINDOW_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [wpa_pkg::ENTRY_W-1:0]   s_tdata,  // pos_x, pos_y, pos_z, q_x, q_y, q_z, q_w
    input  logic [0:0]                    s_tuser,  // opcode
    // result items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wpa_pkg::RESULT_W-1:0]  m_tdata,  // mean_x/y/z, quat_x/y/z/w, var_x/y/z
    output logic [0:0]                    m_tuser,  // quat_valid
    // configuration writes
    input  logic                          cfg_wr_en,
    input  logic [wpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wpa_pkg::CFG_W-1:0]     cfg_data
);
    import wpa_pkg::*;

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int DIV_W = 50 + CW;

    wpa_cfg_t           cfg;
    logic               q_valid;
    wpa_item_t          q_item;
    logic               q_pop;

    // ring memory port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // shared divider
    logic               div_start;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   div_den;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;

    // front: accept and classify items, hold configuration
    wpa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // one entry per stored measurement
    wpa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wpa_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // back: ring upkeep and tick computation
    wpa_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .AW         (AW),
        .CW         (CW),
        .DIV_W      (DIV_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .div_start (div_start),
        .div_num   (div_num),
        .div_den   (div_den),
        .div_done  (div_done),
        .div_quo   (div_quo),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== sv/wpa_checker.sv =====
// ----------------------------------------------------------------------------
// wpa_checker
// port-level checks on the result channel of the window pose averager
// ----------------------------------------------------------------------------
`include "window_pose_averager_assert.svh"

module wpa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wpa_pkg::RESULT_W-1:0]  m_tdata,
    input logic [0:0]                    m_tuser
);

    logic signed [15:0] quat_x;
    logic signed [15:0] quat_w;
    logic               stall;

    assign quat_x = m_tdata[111:96];
    assign quat_w = m_tdata[159:144];
    assign stall  = m_tvalid && !m_tready;

    // stalled result holds
    `WPA_ASSERT_NXT(a_hold, stall, m_tvalid && $stable({m_tuser, m_tdata}), "stalled result changed")

    // invalid quaternion comes out as zeros
    `WPA_ASSERT_IMP(a_qzero, m_tvalid && !m_tuser[0], m_tdata[159:96] == 64'd0, "quaternion not zero")

    // normalized components stay within one
    `WPA_ASSERT_IMP(a_qrange_x, m_tvalid, quat_x <= 16384 && quat_x >= -16384, "quat_x out of range")
    `WPA_ASSERT_IMP(a_qrange_w, m_tvalid, quat_w <= 16384 && quat_w >= -16384, "quat_w out of range")

endmodule

bind window_pose_averager wpa_checker u_wpa_checker (.*);
